// File: design/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int unsigned BLOCK_BYTES = 64;
	localparam int unsigned ROUNDS      = 64;

	localparam logic [7:0] PAD_BYTE   = 8'h80;
	localparam logic [5:0] LAST_BYTE  = 6'd63;
	localparam logic [5:0] LAST_ZERO  = 6'd55;
	localparam logic [5:0] LENGTH_POS = 6'd56;
	localparam logic [63:0] BLOCK_BITS = 64'd512;

	typedef logic [7:0][31:0]  hash_arr_t;
	typedef logic [15:0][31:0] sched_arr_t;

	localparam hash_arr_t INIT_H = {
		32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
		32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
	};

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
		32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
		32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
		32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
		32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
		32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	// Control from the sequencer to the compression core
	typedef struct packed {
		logic       wr_en;
		logic [5:0] wr_idx;
		logic [7:0] wr_byte;
		logic       start;
		logic       init;
	} core_ctl_t;

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// File: design/sha256_core.sv
// ----------------------------------------------------------------------------
// sha256_core
// Block buffer, message schedule window and one-round-per-cycle compression.
// ----------------------------------------------------------------------------
module sha256_core
	import sha256_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  core_ctl_t ctl,
	output logic      busy,
	output hash_arr_t hash
);

	typedef enum logic [2:0] {
		C_IDLE   = 3'b001,
		C_ROUND  = 3'b010,
		C_UPDATE = 3'b100
	} core_state_t;

	core_state_t state_q;
	logic [5:0]  round_q;
	hash_arr_t   h_q;
	hash_arr_t   v_q;
	sched_arr_t  w_q;

	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_new;
	logic [31:0] ch;
	logic [31:0] maj;

	always_comb begin
		ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1    = v_q[7] + big_sigma1(v_q[4]) + ch + ROUND_K[round_q] + w_q[0];
		t2    = big_sigma0(v_q[0]) + maj;
		w_new = w_q[0] + small_sigma0(w_q[1]) + w_q[9] + small_sigma1(w_q[14]);
	end

	// Window doubles as the block buffer: bytes land big-endian in their word
	always_ff @(posedge clk) begin
		if (state_q == C_ROUND) begin
			w_q <= {w_new, w_q[15:1]};
		end else if (ctl.wr_en) begin
			w_q[ctl.wr_idx[5:2]][{~ctl.wr_idx[1:0], 3'b000} +: 8] <= ctl.wr_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			v_q <= h_q;
		end else if (state_q == C_ROUND) begin
			v_q <= {v_q[6], v_q[5], v_q[4], v_q[3] + t1, v_q[2], v_q[1], v_q[0], t1 + t2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			round_q <= '0;
			h_q     <= INIT_H;
		end else begin
			case (state_q)
				C_IDLE: begin
					round_q <= '0;
					if (ctl.init) begin
						h_q <= INIT_H;
					end
					if (ctl.start) begin
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'(ROUNDS - 1)) begin
						state_q <= C_UPDATE;
					end
				end
				C_UPDATE: begin
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= h_q[i] + v_q[i];
					end
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != C_IDLE);
	assign hash = h_q;

endmodule

// File: design/sha256_byte_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// SHA-256 over a byte stream, digest out as eight 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: each item is one message byte (s_tuser = 0) or a finish
//   command (s_tuser = 1, s_tdata ignored). Master channel: after a finish the
//   block sends eight items, digest word 0 (most significant) first, with
//   m_tlast on word 7.
//   Timing: bytes are taken one per cycle while s_tready is high. The 64th
//   byte of a block starts the compression, which runs one round per cycle
//   in the shared round unit and then updates the hash; s_tready stays low
//   until the sequencer sees the core idle again. A finish writes the pad
//   byte, zero fill and length one byte per cycle (with an extra compression
//   when more than 55 bytes are pending), runs the final compression, then
//   offers the digest, one word per cycle while the receiver takes them.
//   The receiver may stall at any time: the current word holds on m_tdata and
//   s_tready stays low until the eighth word is taken, after which the hash
//   restarts from the initial values.
//   Reset: arst_n clears the sequencer, byte count and bit count and loads
//   the initial hash values; the block is ready as soon as it is released.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_top
	import sha256_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
	output logic        m_tlast    // last
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001, // take bytes and finish items
		ST_BLK  = 7'b0000010, // compress a full data block
		ST_PAD  = 7'b0000100, // write zero fill
		ST_PADC = 7'b0001000, // compress the extra padding block
		ST_LEN  = 7'b0010000, // write the big-endian bit length
		ST_LENC = 7'b0100000, // final compression
		ST_OUT  = 7'b1000000  // offer digest words
	} state_t;

	state_t      state_q;
	logic [5:0]  fill_q;     // bytes pending in the block
	logic [63:0] bits_q;     // compressed message bits, then length shifter
	logic [2:0]  word_q;
	logic        m_valid_q;

	core_ctl_t   ctl;
	logic        core_busy;
	hash_arr_t   hash;

	logic        s_accept;
	logic        m_accept;

	assign s_accept = s_tvalid && s_tready;
	assign m_accept = m_tvalid && m_tready;
	assign s_tready = (state_q == ST_IDLE);

	// Sequencer drive to the core: one byte per cycle while fed, start on byte 63
	always_comb begin
		ctl         = '0;
		ctl.wr_idx  = fill_q;
		ctl.wr_byte = s_tdata;
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					ctl.wr_en   = 1'b1;
					ctl.wr_byte = s_tuser ? PAD_BYTE : s_tdata;
					ctl.start   = (fill_q == LAST_BYTE);
				end
			end
			ST_PAD: begin
				ctl.wr_en   = 1'b1;
				ctl.wr_byte = '0;
				ctl.start   = (fill_q == LAST_BYTE);
			end
			ST_LEN: begin
				ctl.wr_en   = 1'b1;
				ctl.wr_byte = bits_q[63:56];
				ctl.start   = (fill_q == LAST_BYTE);
			end
			ST_OUT: begin
				ctl.init = m_accept && (word_q == 3'd7);
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			bits_q    <= '0;
			word_q    <= '0;
			m_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						// fill wraps to zero after byte 63
						fill_q <= fill_q + 6'd1;
						if (!s_tuser) begin
							if (fill_q == LAST_BYTE) begin
								bits_q  <= bits_q + BLOCK_BITS;
								state_q <= ST_BLK;
							end
						end else begin
							// fold the pending bytes into the length
							bits_q <= bits_q + {55'b0, fill_q, 3'b000};
							if (fill_q == LAST_BYTE) begin
								state_q <= ST_PADC;
							end else if (fill_q == LAST_ZERO) begin
								state_q <= ST_LEN;
							end else begin
								state_q <= ST_PAD;
							end
						end
					end
				end
				ST_BLK: begin
					if (!core_busy) begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == LAST_BYTE) begin
						state_q <= ST_PADC;
					end else if (fill_q == LAST_ZERO) begin
						state_q <= ST_LEN;
					end
				end
				ST_PADC: begin
					if (!core_busy) begin
						state_q <= ST_PAD;
					end
				end
				ST_LEN: begin
					fill_q <= fill_q + 6'd1;
					bits_q <= {bits_q[55:0], 8'h00};
					if (fill_q == LAST_BYTE) begin
						state_q <= ST_LENC;
					end
				end
				ST_LENC: begin
					if (!core_busy) begin
						word_q    <= '0;
						m_valid_q <= 1'b1;
						state_q   <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (m_accept) begin
						if (word_q == 3'd7) begin
							// drop the digest, restart the message
							m_valid_q <= 1'b0;
							bits_q    <= '0;
							state_q   <= ST_IDLE;
						end else begin
							word_q <= word_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	sha256_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.busy   (core_busy),
		.hash   (hash)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b00000, word_q, hash[word_q]};
	assign m_tlast  = (word_q == 3'd7);

	// Core must be idle whenever a block is launched
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !core_busy)
		else $error("compression started while core busy");

	// Length bytes land only in the last eight buffer slots
	a_len_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LEN) |-> (fill_q >= LENGTH_POS))
		else $error("length written below byte 56");

	// A finish item closes the input until the digest is out; only the closing is checked
	a_finish_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && s_tuser) |=> !s_tready)
		else $error("input open right after finish");

	// Digest words are offered only by the output state, never with input open
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((state_q == ST_OUT) && !s_tready))
		else $error("digest valid outside output state");

endmodule
